>>> hdl/i2a_pkg.sv
// ---------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers for the integer to ASCII digit
// converter.
// ---------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int ITEM_BITS      = 64;
    localparam int DIGITS         = 20;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_W          = 6;
    localparam int COUNT_W        = 5;

    localparam logic [CFG_W-1:0]   MAX_CHARS_RESET = 6'd32;
    localparam logic [COUNT_W-1:0] LIMIT_MAX       = 5'd21;

    localparam logic [6:0] CHAR_ZERO   = 7'h30;
    localparam logic [6:0] CHAR_ALPHA  = 7'h61;
    localparam logic [6:0] CHAR_MINUS  = 7'h2D;
    localparam logic [3:0] DEC_BASE    = 4'd10;

    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;

    typedef struct packed {
        logic [ITEM_BITS-1:0] value;
        logic [1:0]           mode;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         char_code;
        logic               last;
        logic [COUNT_W-1:0] char_count;
    } t_out_item;

    typedef struct packed {
        logic neg;
        logic hex;
    } t_job_flags;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CONV,
        B_COUNT,
        B_SIGN,
        B_EMIT
    } t_back_state;

    function automatic logic [6:0] ascii_of(input logic [3:0] d);
        logic [6:0] r;
        if (d < DEC_BASE) begin
            r = CHAR_ZERO + 7'(d);
        end else begin
            r = CHAR_ALPHA + 7'(d - DEC_BASE);
        end
        return r;
    endfunction

endpackage

>>> hdl/i2a_fifo.sv
// ---------------------------------------------------------------------------
// i2a_fifo
// Short register queue between the front and back parts.
// ---------------------------------------------------------------------------
module i2a_fifo #(
    parameter int WIDTH = 66,
    parameter int DEPTH = i2a_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output i2a_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             w_wr, w_rd;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/i2a_front.sv
// ---------------------------------------------------------------------------
// i2a_front
// Accepts commands, masks the value, picks the radix and forms the
// unsigned magnitude of negative signed values.
// ---------------------------------------------------------------------------
module i2a_front #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_start,
    input  i2a_pkg::t_in_item     i_item,
    input  i2a_pkg::t_q_status    i_q_status,
    output logic                  o_busy,
    output logic                  o_push,
    output i2a_pkg::t_job_flags   o_flags,
    output logic [VALUE_BITS-1:0] o_mag
);

    logic [VALUE_BITS-1:0] w_v;
    logic                  w_signed;

    assign w_v      = i_item.value[VALUE_BITS-1:0];
    assign w_signed = (i_item.mode == i2a_pkg::MODE_SDEC);

    assign o_flags.neg = w_signed && w_v[VALUE_BITS-1];
    assign o_flags.hex = (i_item.mode != i2a_pkg::MODE_SDEC)
                      && (i_item.mode != i2a_pkg::MODE_UDEC);
    assign o_mag       = o_flags.neg ? (~w_v + 1'b1) : w_v;

    assign o_busy = i_q_status.full;
    assign o_push = i_start && !i_q_status.full;

endmodule

>>> hdl/i2a_back.sv
// ---------------------------------------------------------------------------
// i2a_back
// Converts one queued magnitude to digits (shift-add-3 for decimal, nibble
// load for hex), sizes the string and emits one character per cycle.
// ---------------------------------------------------------------------------
module i2a_back #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [i2a_pkg::CFG_W-1:0]   i_max_chars,
    input  i2a_pkg::t_q_status          i_q_status,
    input  i2a_pkg::t_job_flags         i_flags,
    input  logic [VALUE_BITS-1:0]       i_mag,
    output logic                        o_pop,
    output logic                        o_res_valid,
    output i2a_pkg::t_out_item          o_res
);

    localparam int DIG_W = i2a_pkg::DIGITS * 4;
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int CW    = i2a_pkg::COUNT_W;

    i2a_pkg::t_back_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_shift, n_shift;
    logic [DIG_W-1:0]      r_bcd,   n_bcd;
    logic [BIT_W-1:0]      r_bitcnt, n_bitcnt;
    logic                  r_neg,   n_neg;
    logic                  r_hex,   n_hex;
    logic [CW-1:0]         r_k,     n_k;
    logic [CW-1:0]         r_total, n_total;
    logic                  r_res_valid, n_res_valid;
    i2a_pkg::t_out_item    r_res,   n_res;

    logic [DIG_W-1:0]      w_adj;
    logic [CW-1:0]         w_ndig, w_lim, w_cnt, w_idx;
    logic                  w_sign;
    logic [3:0]            w_digit;

    always_comb begin
        for (int i = 0; i < i2a_pkg::DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        w_ndig = CW'(1);
        for (int i = 0; i < i2a_pkg::DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_ndig = CW'(i + 1);
            end
        end
    end

    always_comb begin
        if (i_max_chars == '0) begin
            w_lim = CW'(1);
        end else if (i_max_chars > {1'b0, i2a_pkg::LIMIT_MAX}) begin
            w_lim = i2a_pkg::LIMIT_MAX;
        end else begin
            w_lim = i_max_chars[CW-1:0];
        end
    end

    assign w_cnt   = (w_ndig < w_lim) ? w_ndig : w_lim;
    assign w_sign  = r_neg && (({1'b0, w_cnt} + 6'd1) < i_max_chars);
    assign w_idx   = r_k - 1'b1;
    assign w_digit = r_bcd[{w_idx, 2'b00} +: 4];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2a_pkg::B_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = i_flags.hex ? i2a_pkg::B_COUNT : i2a_pkg::B_CONV;
                end
            end
            i2a_pkg::B_CONV: begin
                if (r_bitcnt == BIT_W'(VALUE_BITS - 1)) begin
                    n_state = i2a_pkg::B_COUNT;
                end
            end
            i2a_pkg::B_COUNT: begin
                n_state = w_sign ? i2a_pkg::B_SIGN : i2a_pkg::B_EMIT;
            end
            i2a_pkg::B_SIGN: begin
                n_state = i2a_pkg::B_EMIT;
            end
            i2a_pkg::B_EMIT: begin
                if (r_k == CW'(1)) begin
                    n_state = i2a_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_shift     = r_shift;
        n_bcd       = r_bcd;
        n_bitcnt    = r_bitcnt;
        n_neg       = r_neg;
        n_hex       = r_hex;
        n_k         = r_k;
        n_total     = r_total;
        n_res_valid = 1'b0;
        n_res       = r_res;
        unique case (r_state)
            i2a_pkg::B_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop    = 1'b1;
                    n_neg    = i_flags.neg;
                    n_hex    = i_flags.hex;
                    n_shift  = i_mag;
                    n_bitcnt = '0;
                    n_bcd    = i_flags.hex ? DIG_W'(i_mag) : '0;
                end
            end
            i2a_pkg::B_CONV: begin
                n_bcd    = {w_adj[DIG_W-2:0], r_shift[VALUE_BITS-1]};
                n_shift  = {r_shift[VALUE_BITS-2:0], 1'b0};
                n_bitcnt = r_bitcnt + 1'b1;
            end
            i2a_pkg::B_COUNT: begin
                n_k     = w_cnt;
                n_total = w_cnt + CW'(w_sign);
            end
            i2a_pkg::B_SIGN: begin
                n_res_valid      = 1'b1;
                n_res.char_code  = i2a_pkg::CHAR_MINUS;
                n_res.last       = 1'b0;
                n_res.char_count = '0;
            end
            i2a_pkg::B_EMIT: begin
                n_res_valid      = 1'b1;
                n_res.char_code  = i2a_pkg::ascii_of(w_digit);
                n_res.last       = (r_k == CW'(1));
                n_res.char_count = (r_k == CW'(1)) ? r_total : '0;
                n_k              = r_k - 1'b1;
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2a_pkg::B_IDLE;
            r_res_valid <= 1'b0;
            r_neg       <= 1'b0;
            r_hex       <= 1'b0;
            r_k         <= '0;
            r_total     <= '0;
            r_bitcnt    <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_neg       <= n_neg;
            r_hex       <= n_hex;
            r_k         <= n_k;
            r_total     <= n_total;
            r_bitcnt    <= n_bitcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> hdl/integer_to_ascii_digits_top.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_digits_top
// Formats a value as signed decimal, unsigned decimal or lowercase hex and
// streams the ASCII characters out most significant first.
// ---------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low; a two-entry
// queue lets up to two commands wait while one is converted. Each character
// appears for one cycle with o_res_valid and must be taken then; the final
// one carries last and the character count. Per command the back part
// fetches the job, runs the shift-add-3 passes for decimal (none for hex),
// sizes the string, then emits one character per cycle, up to 21 in all.
module integer_to_ascii_digits_top #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  i2a_pkg::t_in_item         i_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [i2a_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_res_valid,
    output i2a_pkg::t_out_item        o_res
);

    localparam int JOB_W = VALUE_BITS + 2;

    logic [i2a_pkg::CFG_W-1:0] r_max_chars;
    logic                      w_push, w_pop;
    i2a_pkg::t_job_flags       w_in_flags, w_q_flags;
    logic [VALUE_BITS-1:0]     w_in_mag, w_q_mag;
    i2a_pkg::t_q_status        w_q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= i2a_pkg::MAX_CHARS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_chars <= i_cfg_data;
        end
    end

    i2a_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_start    (i_start),
        .i_item     (i_item),
        .i_q_status (w_q_status),
        .o_busy     (o_busy),
        .o_push     (w_push),
        .o_flags    (w_in_flags),
        .o_mag      (w_in_mag)
    );

    i2a_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (i2a_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   ({w_in_flags, w_in_mag}),
        .i_pop    (w_pop),
        .o_data   ({w_q_flags, w_q_mag}),
        .o_status (w_q_status)
    );

    i2a_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_chars (r_max_chars),
        .i_q_status  (w_q_status),
        .i_flags     (w_q_flags),
        .i_mag       (w_q_mag),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
